FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the selective repeat receiver.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: design/srr_pkg.sv
// Package of the selective repeat receiver: widths, descriptor and result
// types, sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srr_pkg;
  localparam int SEQ_SPACE = 16;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);
  localparam int WIN_W     = 4;
  localparam int WIN_MAX   = SEQ_SPACE / 2;
  localparam int WIN_RESET = 4;
  localparam int DRAIN_MAX = SEQ_SPACE / 2 - 1;
  localparam int DRAIN_W   = $clog2(DRAIN_MAX + 1);
  localparam int HANDLE_W  = 16;
  localparam int LEN_W     = 8;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } desc_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    desc_t            desc;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [SEQ_W-1:0] waddr;
    desc_t            wdata;
    logic             re;
    logic [SEQ_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DELIV,
    S_LOOK,
    S_READ,
    S_ACK
  } state_t;
endpackage
`default_nettype wire

FILE: design/srr_pkt_if.sv
// Packet descriptor channel: valid/ready handshake with seq, check flag,
// payload handle and length. Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface srr_pkt_if;
  import srr_pkg::*;
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    seq_num;
  logic                check_ok;
  logic [HANDLE_W-1:0] payload_handle;
  logic [LEN_W-1:0]    payload_len;

  modport source (output valid, seq_num, check_ok, payload_handle, payload_len,
                  input ready);
  modport sink   (input valid, seq_num, check_ok, payload_handle, payload_len,
                  output ready);
endinterface
`default_nettype wire

FILE: design/srr_res_if.sv
// Result channel: deliver or ACK items with valid/ready handshake.
// Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface srr_res_if;
  import srr_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    out_len;
  logic                last;

  modport source (output valid, kind, out_seq, out_handle, out_len, last,
                  input ready);
  modport sink   (input valid, kind, out_seq, out_handle, out_len, last,
                  output ready);
endinterface
`default_nettype wire

FILE: design/srr_desc_ram.sv
// Held descriptor store: one write port, one registered read port.
// Depends on srr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srr_desc_ram (
  input  wire logic             clk,
  input  wire srr_pkg::ram_req_t req,
  output srr_pkg::desc_t        rdata
);
  import srr_pkg::*;

  desc_t mem [SEQ_SPACE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

FILE: design/srr_ctrl.sv
// Receive sequencer: window check, received marks, in-order drain and the
// result register. Depends on srr_pkg, srr_pkt_if, srr_res_if, assert_macros.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [srr_pkg::WIN_W-1:0] cfg_wdata,
  srr_pkt_if.sink                   pkt,
  srr_res_if.source                 res,
  output srr_pkg::ram_req_t         ram_req,
  input  wire srr_pkg::desc_t       ram_rdata
);
  import srr_pkg::*;

  state_t               state, state_next;
  logic [WIN_W-1:0]     window_size;
  logic [SEQ_W-1:0]     expected;
  logic [SEQ_SPACE-1:0] marks;
  logic [DRAIN_W-1:0]   drained;
  logic [SEQ_W-1:0]     cur_seq;
  logic                 cur_ok;
  desc_t                cur_desc;
  logic                 out_valid;
  result_t              out_q;

  logic [WIN_W-1:0] win_eff;
  logic [SEQ_W-1:0] alu_out;
  logic             in_window;
  logic             slot_free;
  logic             emit;
  result_t          emit_val;
  logic             set_mark, clr_mark, exp_inc, drain_clr, drain_inc;

  always_comb begin
    if (window_size == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_size > WIN_W'(WIN_MAX)) begin
      win_eff = WIN_W'(WIN_MAX);
    end else begin
      win_eff = window_size;
    end
  end

  // shared adder: window offset during check, expected + 1 otherwise
  assign alu_out   = (state == S_CHECK) ? (cur_seq - expected) : (expected + 1'b1);
  assign in_window = cur_ok && (WIN_W'(alu_out) < win_eff);
  assign slot_free = !out_valid || res.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (pkt.valid) state_next = S_CHECK;
      S_CHECK: begin
        if (!in_window) state_next = S_IDLE;
        else if (alu_out == '0) state_next = S_DELIV;
        else state_next = S_ACK;
      end
      S_DELIV: if (slot_free) state_next = S_LOOK;
      S_LOOK: begin
        if (drained != DRAIN_W'(DRAIN_MAX) && marks[expected]) state_next = S_READ;
        else state_next = S_ACK;
      end
      S_READ:  if (slot_free) state_next = S_LOOK;
      S_ACK:   if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pkt.ready     = 1'b0;
    emit          = 1'b0;
    emit_val      = '0;
    set_mark      = 1'b0;
    clr_mark      = 1'b0;
    exp_inc       = 1'b0;
    drain_clr     = 1'b0;
    drain_inc     = 1'b0;
    ram_req       = '0;
    ram_req.waddr = cur_seq;
    ram_req.wdata = cur_desc;
    ram_req.raddr = expected;
    case (state)
      S_IDLE: pkt.ready = 1'b1;
      S_CHECK: begin
        if (in_window && alu_out != '0) begin
          ram_req.we = 1'b1;
          set_mark   = 1'b1;
        end
      end
      S_DELIV: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_val  = '{kind: KIND_DELIVER, seq: cur_seq, desc: cur_desc, last: 1'b0};
          exp_inc   = 1'b1;
          drain_clr = 1'b1;
        end
      end
      S_LOOK: ram_req.re = 1'b1;
      S_READ: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_val  = '{kind: KIND_DELIVER, seq: expected, desc: ram_rdata, last: 1'b0};
          clr_mark  = 1'b1;
          exp_inc   = 1'b1;
          drain_inc = 1'b1;
        end
      end
      S_ACK: begin
        if (slot_free) begin
          emit     = 1'b1;
          emit_val = '{kind: KIND_ACK, seq: cur_seq, desc: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= WIN_W'(WIN_RESET);
      expected    <= '0;
      marks       <= '0;
      drained     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) window_size <= cfg_wdata;
      if (exp_inc) expected <= alu_out;
      if (set_mark) marks[cur_seq] <= 1'b1;
      if (clr_mark) marks[expected] <= 1'b0;
      if (drain_clr) drained <= '0;
      else if (drain_inc) drained <= drained + 1'b1;
      if (emit) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      cur_seq  <= pkt.seq_num;
      cur_ok   <= pkt.check_ok;
      cur_desc <= '{handle: pkt.payload_handle, len: pkt.payload_len};
    end
    if (emit) out_q <= emit_val;
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_q.kind;
  assign res.out_seq    = out_q.seq;
  assign res.out_handle = out_q.desc.handle;
  assign res.out_len    = out_q.desc.len;
  assign res.last       = out_q.last;

  `ASSERT_CLK(a_exp_moves_on_delivery, clk, rst,
    (!$past(rst) && expected != $past(expected)) |->
      ($past(state) == S_DELIV || $past(state) == S_READ))
  `ASSERT_NEVER(a_no_mark_at_expected_idle, clk, rst,
    state == S_IDLE && marks[expected])
  `ASSERT_CLK(a_last_is_ack, clk, rst,
    (res.valid && res.last) |-> (res.kind == KIND_ACK && res.out_handle == '0))
endmodule
`default_nettype wire

FILE: design/selective_repeat_receiver.sv
// Top level of the selective repeat ARQ receiver.
// Depends on srr_pkg, srr_pkt_if, srr_res_if, srr_ctrl, srr_desc_ram.
//
// Channels: pkt carries one arriving packet descriptor per transfer (valid and
// ready high at a rising edge). res carries results: deliveries (kind 0) in
// sequence order, then one ACK (kind 1, last 1) per packet inside the window.
// Corrupt or out-of-window packets give no result.
// cfg_we/cfg_wdata write window_size (reset 4); write only while idle.
// Sequence: pkt is taken in the idle state, then the sequencer checks the window
// in the next cycle. An out-of-order packet is stored and ACKed. An in-order
// packet is delivered together with the n held packets following it (n at most
// 7): each held descriptor needs a lookup state and a registered read of the
// descriptor store.
// One result register sits on res; a stall of res holds the sequencer until the
// register frees, and no result is lost or repeated.
// Reset (synchronous, rst high) clears expected sequence, all received marks
// and the result register; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_receiver (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [srr_pkg::WIN_W-1:0] cfg_wdata,
  srr_pkt_if.sink                        pkt,
  srr_res_if.source                      res
);
  import srr_pkg::*;

  ram_req_t ram_req;
  desc_t    ram_rdata;

  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pkt       (pkt),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  srr_desc_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire
